/* rtl/section_address_translate_unit_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the section address translate unit
// Shorthand for clocked assertions with a synchronous reset disable.
// ----------------------------------------------------------------------------
`ifndef SECTION_ADDRESS_TRANSLATE_UNIT_ASSERT_SVH
`define SECTION_ADDRESS_TRANSLATE_UNIT_ASSERT_SVH

// trig in this cycle implies cond in the same cycle
`define SAT_ASSERT_NOW(label, clk, rst, trig, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
      else $error("%m: check failed");

// trig in this cycle implies cond in the next cycle
`define SAT_ASSERT_NEXT(label, clk, rst, trig, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
      else $error("%m: check failed");

`endif

/* rtl/sat_pkg.sv */
// ----------------------------------------------------------------------------
// sat_pkg
// Types, codes and helpers shared by the section address translate unit.
// ----------------------------------------------------------------------------
`default_nettype none

package sat_pkg;

   localparam int MAX_SECTIONS_DEF = 16;
   localparam int PAGE_BITS        = 12;
   localparam logic [31:0] PAGE_SIZE         = 32'h0000_1000;
   localparam logic [31:0] HEADER_SIZE_RST   = 32'd1024;
   localparam logic [4:0]  SECTION_COUNT_RST = 5'd0;

   typedef logic [1:0] mode_type;
   localparam mode_type MODE_WRITE = 2'd0;
   localparam mode_type MODE_V2F   = 2'd1;
   localparam mode_type MODE_F2V   = 2'd2;

   typedef logic [1:0] csr_index_type;
   localparam csr_index_type CSR_SECTION_COUNT = 2'd0;
   localparam csr_index_type CSR_HEADER_SIZE   = 2'd1;

   typedef struct packed {
      mode_type    mode;
      logic [3:0]  slot;
      logic [31:0] virtual_size;
      logic [31:0] virtual_base;
      logic [31:0] raw_size;
      logic [31:0] raw_offset;
      logic [31:0] address;
   } req_type;

   typedef struct packed {
      logic [31:0] translated;
      logic        found;
   } rsp_type;

   typedef struct packed {
      logic [31:0] virtual_size;
      logic [31:0] virtual_base;
      logic [31:0] raw_size;
      logic [31:0] raw_offset;
   } sect_type;

   typedef struct packed {
      logic start;
      logic write;
      logic rd_en;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic pass;
      logic busy;
      logic out_free;
   } status_type;

   function automatic logic [31:0] round_up_page(input logic [31:0] v);
      logic [31:0] r;
      r = v;
      if (v[PAGE_BITS-1:0] != '0) begin
         r = {v[31:PAGE_BITS], {PAGE_BITS{1'b0}}} + PAGE_SIZE;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

/* rtl/sat_ram.sv */
// ----------------------------------------------------------------------------
// sat_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module sat_ram #(
   parameter int WIDTH = 128,
   parameter int DEPTH = 16,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output      logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* rtl/sat_ctrl.sv */
// ----------------------------------------------------------------------------
// sat_ctrl
// Sequencer: accepts items, steps the table scan and hands off the result.
// ----------------------------------------------------------------------------
`default_nettype none

module sat_ctrl #(
   parameter int MAX_SECTIONS = 16,
   parameter int IDX_W        = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1,
   parameter int CNT_W        = $clog2(MAX_SECTIONS + 1)
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   input  wire sat_pkg::mode_type    req_mode,
   output      logic                 req_stall,
   input  wire sat_pkg::status_type  status,
   input  wire logic [CNT_W-1:0]     used_count,
   output      sat_pkg::cmd_type     cmd,
   output      logic [IDX_W-1:0]     rd_addr
);

   import sat_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FLUSH,
      ST_HOLD
   } state_type;

   state_type        state_ff, state_in;
   logic [IDX_W-1:0] idx_ff, idx_in;

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               case (req_mode)
                  MODE_WRITE: begin
                     cmd.write = 1'b1;
                  end
                  MODE_V2F, MODE_F2V: begin
                     cmd.start = 1'b1;
                     if ((req_mode == MODE_V2F && status.pass) || used_count == '0) begin
                        state_in = ST_HOLD;
                     end else begin
                        state_in = ST_SCAN;
                        idx_in   = '0;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_SCAN: begin
            cmd.rd_en = 1'b1;
            if (CNT_W'(idx_ff) + CNT_W'(1) == used_count) begin
               state_in = ST_FLUSH;
            end else begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end
         ST_FLUSH: begin
            if (!status.busy) begin
               state_in = ST_HOLD;
            end
         end
         ST_HOLD: begin
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rd_addr   = idx_ff;

endmodule

`default_nettype wire

/* rtl/sat_datapath.sv */
// ----------------------------------------------------------------------------
// sat_datapath
// Section table, registers, two-stage range match and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module sat_datapath #(
   parameter int MAX_SECTIONS = 16,
   parameter int IDX_W        = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1,
   parameter int CNT_W        = $clog2(MAX_SECTIONS + 1)
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire sat_pkg::req_type       req_data,
   input  wire logic                   csr_wen,
   input  wire sat_pkg::csr_index_type csr_index,
   input  wire logic [31:0]            csr_wdata,
   input  wire sat_pkg::cmd_type       cmd,
   input  wire logic [IDX_W-1:0]       rd_addr,
   output      sat_pkg::status_type    status,
   output      logic [CNT_W-1:0]       used_count,
   output      logic                   rsp_valid,
   input  wire logic                   rsp_stall,
   output      sat_pkg::rsp_type       rsp_data
);

   import sat_pkg::*;

   logic [4:0]              section_count_ff;
   logic [31:0]             header_size_ff;
   logic [MAX_SECTIONS-1:0] valid_ff;
   mode_type                mode_ff;
   logic [31:0]             addr_ff;
   logic                    vld1_ff;
   logic                    entry_vld_ff;
   logic                    vld2_ff;
   logic                    lo_ok_ff;
   logic [31:0]             end_ff;
   logic [31:0]             diff_ff;
   logic [31:0]             other_ff;
   logic [31:0]             result_ff;
   logic                    found_ff;
   logic                    rsp_valid_ff;
   rsp_type                 rsp_data_ff;

   logic            wr_en;
   logic [IDX_W-1:0] wr_addr;
   sect_type        wr_entry;
   sect_type        ram_q;
   sect_type        entry;
   logic [31:0]     base;
   logic [31:0]     end_in;
   logic [31:0]     other_in;

   assign wr_en   = cmd.write && (32'(req_data.slot) < 32'(MAX_SECTIONS));
   assign wr_addr = IDX_W'(req_data.slot);

   always_comb begin
      wr_entry.virtual_size = req_data.virtual_size;
      wr_entry.virtual_base = req_data.virtual_base;
      wr_entry.raw_size     = req_data.raw_size;
      wr_entry.raw_offset   = req_data.raw_offset;
   end

   sat_ram #(
      .WIDTH ($bits(sect_type)),
      .DEPTH (MAX_SECTIONS),
      .AW    (IDX_W)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_en   (cmd.rd_en),
      .rd_addr (rd_addr),
      .rd_data (ram_q)
   );

   always_comb begin
      if (32'(section_count_ff) > 32'(MAX_SECTIONS)) begin
         used_count = CNT_W'(MAX_SECTIONS);
      end else begin
         used_count = CNT_W'(section_count_ff);
      end
   end

   assign entry = entry_vld_ff ? ram_q : '0;

   always_comb begin
      if (mode_ff == MODE_V2F) begin
         base     = entry.virtual_base;
         end_in   = round_up_page(entry.virtual_size) + entry.virtual_base;
         other_in = entry.raw_offset;
      end else begin
         base     = entry.raw_offset;
         end_in   = entry.raw_size + entry.raw_offset;
         other_in = entry.virtual_base;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         section_count_ff <= SECTION_COUNT_RST;
         header_size_ff   <= HEADER_SIZE_RST;
         valid_ff         <= '0;
         vld1_ff          <= 1'b0;
         vld2_ff          <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         if (csr_wen) begin
            case (csr_index)
               CSR_SECTION_COUNT: section_count_ff <= csr_wdata[4:0];
               CSR_HEADER_SIZE:   header_size_ff   <= csr_wdata;
               default: ;
            endcase
         end
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         vld1_ff <= cmd.rd_en;
         vld2_ff <= vld1_ff;
         if (cmd.load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         entry_vld_ff <= valid_ff[rd_addr];
      end
      lo_ok_ff <= (addr_ff >= base);
      end_ff   <= end_in;
      diff_ff  <= addr_ff - base;
      other_ff <= other_in;
      if (cmd.start) begin
         mode_ff <= req_data.mode;
         addr_ff <= req_data.address;
         if (req_data.mode == MODE_V2F && status.pass) begin
            result_ff <= req_data.address;
            found_ff  <= 1'b1;
         end else begin
            result_ff <= '0;
            found_ff  <= 1'b0;
         end
      end else if (vld2_ff && lo_ok_ff && (addr_ff < end_ff)) begin
         result_ff <= diff_ff + other_ff;
         found_ff  <= 1'b1;
      end
      if (cmd.load_out) begin
         rsp_data_ff.translated <= result_ff;
         rsp_data_ff.found      <= found_ff;
      end
   end

   assign status.pass     = (req_data.address <= header_size_ff);
   assign status.busy     = vld1_ff | vld2_ff;
   assign status.out_free = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

/* rtl/section_address_translate_unit.sv */
// ----------------------------------------------------------------------------
// section_address_translate_unit
// Section table lookup between virtual addresses and file offsets.
// ----------------------------------------------------------------------------
// Slot write: accepted with no stall, no result. Header passthrough or empty
// table: straight to the hold state, result loaded once the output register is
// free. Table lookup: scan, flush and hold states, n = min(section_count,
// MAX_SECTIONS) entries, one table read per cycle through the single RAM read
// port; next item taken once the result moves to the output register. Synchronous
// reset clears the table (valid bits), section_count to 0 and header_size to 1024.
`default_nettype none

module section_address_translate_unit #(
   parameter int MAX_SECTIONS = sat_pkg::MAX_SECTIONS_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output      logic                   req_stall,
   input  wire sat_pkg::req_type       req_data,
   output      logic                   rsp_valid,
   input  wire logic                   rsp_stall,
   output      sat_pkg::rsp_type       rsp_data,
   input  wire logic                   csr_valid,
   output      logic                   csr_ready,
   input  wire sat_pkg::csr_index_type csr_index,
   input  wire logic [31:0]            csr_wdata
);

   import sat_pkg::*;

   localparam int IDX_W = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
   localparam int CNT_W = $clog2(MAX_SECTIONS + 1);

   cmd_type          cmd;
   status_type       status;
   logic [CNT_W-1:0] used_count;
   logic [IDX_W-1:0] rd_addr;

   assign csr_ready = 1'b1;

   sat_ctrl #(
      .MAX_SECTIONS (MAX_SECTIONS),
      .IDX_W        (IDX_W),
      .CNT_W        (CNT_W)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_mode   (req_data.mode),
      .req_stall  (req_stall),
      .status     (status),
      .used_count (used_count),
      .cmd        (cmd),
      .rd_addr    (rd_addr)
   );

   sat_datapath #(
      .MAX_SECTIONS (MAX_SECTIONS),
      .IDX_W        (IDX_W),
      .CNT_W        (CNT_W)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_data   (req_data),
      .csr_wen    (csr_valid && csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .cmd        (cmd),
      .rd_addr    (rd_addr),
      .status     (status),
      .used_count (used_count),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

endmodule

`default_nettype wire

/* rtl/sat_checker.sv */
// ----------------------------------------------------------------------------
// sat_checker
// Port-level checks on the section address translate unit, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

`include "section_address_translate_unit_assert.svh"

module sat_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_valid,
   input wire logic             req_stall,
   input wire sat_pkg::req_type req_data,
   input wire logic             rsp_valid,
   input wire logic             rsp_stall,
   input wire sat_pkg::rsp_type rsp_data
);

   import sat_pkg::*;

   `SAT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid)
   `SAT_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && rsp_stall, $stable(rsp_data))
   `SAT_ASSERT_NOW(a_miss_zero, clock, reset, rsp_valid && !rsp_data.found, rsp_data.translated == '0)
   `SAT_ASSERT_NEXT(a_write_ready, clock, reset, req_valid && !req_stall && req_data.mode == MODE_WRITE, !req_stall)

endmodule

bind section_address_translate_unit sat_checker u_sat_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

`default_nettype wire

/* verif/sat_translate_checker.sv */
// ----------------------------------------------------------------------------
// sat_translate_checker
// Watches the request, result and register channels of the section address
// translate unit. Keeps its own section table and register copy, works out the
// expected translation for every accepted lookup and compares each result.
// ----------------------------------------------------------------------------

module sat_translate_checker
   import sat_pkg::*;
#(
   parameter int MAX_SECTIONS = MAX_SECTIONS_DEF
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  logic          req_stall,
   input  req_type       req_data,
   input  logic          rsp_valid,
   input  logic          rsp_stall,
   input  rsp_type       rsp_data,
   input  logic          csr_valid,
   input  logic          csr_ready,
   input  csr_index_type csr_index,
   input  logic [31:0]   csr_wdata,
   output int            failures,
   output int            outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   sect_type    sections [MAX_SECTIONS];
   logic [4:0]  section_count;
   logic [31:0] header_limit;
   rsp_type     translation_q [$];
   int          error_count = 0;

   function automatic logic [31:0] page_ceiling(input logic [31:0] size);
      if (size[11:0] == 12'h000) begin
         return size;
      end
      return {size[31:12] + 20'd1, 12'h000};
   endfunction

   function automatic rsp_type translate_address(input req_type item);
      rsp_type     result;
      int          used;
      int          i;
      logic [31:0] extent_end;
      result = '0;
      used = (section_count > MAX_SECTIONS) ? MAX_SECTIONS : int'(section_count);
      if (item.mode == MODE_V2F && item.address <= header_limit) begin
         result.translated = item.address;
         result.found = 1'b1;
      end else begin
         for (i = 0; i < used; i++) begin
            if (item.mode == MODE_V2F) begin
               extent_end = page_ceiling(sections[i].virtual_size) + sections[i].virtual_base;
               if (item.address >= sections[i].virtual_base && item.address < extent_end) begin
                  result.translated = item.address - sections[i].virtual_base
                                      + sections[i].raw_offset;
                  result.found = 1'b1;
               end
            end else begin
               extent_end = sections[i].raw_size + sections[i].raw_offset;
               if (item.address >= sections[i].raw_offset && item.address < extent_end) begin
                  result.translated = item.address - sections[i].raw_offset
                                      + sections[i].virtual_base;
                  result.found = 1'b1;
               end
            end
         end
      end
      return result;
   endfunction

   always @(posedge clock) begin
      rsp_type  wanted;
      sect_type entry;
      if (reset) begin
         foreach (sections[i]) sections[i] = '0;
         section_count = SECTION_COUNT_RST;
         header_limit = HEADER_SIZE_RST;
         translation_q.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (translation_q.size() == 0) begin
               $error("unexpected result: translated %h found %b",
                      rsp_data.translated, rsp_data.found);
               error_count++;
            end else begin
               wanted = translation_q.pop_front();
               if (rsp_data.translated !== wanted.translated) begin
                  $error("translated: expected %h, actual %h",
                         wanted.translated, rsp_data.translated);
                  error_count++;
               end
               if (rsp_data.found !== wanted.found) begin
                  $error("found: expected %b, actual %b", wanted.found, rsp_data.found);
                  error_count++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            case (req_data.mode)
               MODE_WRITE: begin
                  if (req_data.slot < MAX_SECTIONS) begin
                     entry.virtual_size = req_data.virtual_size;
                     entry.virtual_base = req_data.virtual_base;
                     entry.raw_size = req_data.raw_size;
                     entry.raw_offset = req_data.raw_offset;
                     sections[req_data.slot] = entry;
                  end
               end
               MODE_V2F, MODE_F2V: begin
                  translation_q.push_back(translate_address(req_data));
               end
               default: ;
            endcase
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_SECTION_COUNT: section_count = csr_wdata[4:0];
               CSR_HEADER_SIZE:   header_limit = csr_wdata;
               default: ;
            endcase
         end
      end
      failures <= error_count;
      outstanding <= translation_q.size();
   end

endmodule

/* verif/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Drives the section address translate unit with directed slot loads and
// lookups covering boundaries, overlaps, wrapping extents and odd register
// values, then with random phases of table loads and aimed lookups under
// random idling, a long result hold-off and a drain pause.
// ----------------------------------------------------------------------------

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import sat_pkg::*;

   localparam int            HALF_PERIOD   = 10;
   localparam int            RESET_CYCLES  = 11;
   localparam int            SETTLE_CYCLES = 32;
   localparam int            IDLE_PERCENT  = 33;
   localparam int            PHASES        = 8;
   localparam int            PHASE_ITEMS   = 130;
   localparam int            HOLD_PHASE    = 2;
   localparam int            PAUSE_PHASE   = 4;
   localparam int            BURST_PHASE   = 5;
   localparam int            HOLD_CYCLES   = 300;
   localparam longint        TIMEOUT_NS    = 64'd20_000_000;
   localparam mode_type      MODE_NONE     = 2'd3;
   localparam csr_index_type CSR_SPARE_2   = 2'd2;
   localparam csr_index_type CSR_SPARE_3   = 2'd3;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_stall;
   req_type       req_data = '0;
   logic          rsp_valid;
   logic          rsp_stall = 1'b0;
   rsp_type       rsp_data;
   logic          csr_valid = 1'b0;
   logic          csr_ready;
   csr_index_type csr_index = CSR_SECTION_COUNT;
   logic [31:0]   csr_wdata = '0;
   int            failures;
   int            outstanding;

   logic          no_idle = 1'b0;
   logic          hold_request = 1'b0;
   logic          hold_taken = 1'b0;
   int            hold_left = 0;
   sect_type      written [16];
   logic [31:0]   header_now = HEADER_SIZE_RST;

   always #(HALF_PERIOD) clock = ~clock;

   section_address_translate_unit u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   sat_translate_checker u_checker (.*);

   always @(posedge clock) begin
      if (hold_request && !hold_taken) begin
         hold_taken = 1'b1;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= !no_idle && ($urandom_range(0, 99) < IDLE_PERCENT);
      end
   end

   function automatic req_type noise_item();
      req_type item;
      item.mode = mode_type'($urandom_range(0, 3));
      item.slot = 4'($urandom_range(0, 15));
      item.virtual_size = $urandom;
      item.virtual_base = $urandom;
      item.raw_size = $urandom;
      item.raw_offset = $urandom;
      item.address = $urandom;
      return item;
   endfunction

   function automatic req_type query_item(input mode_type mode, input logic [31:0] addr);
      req_type item;
      item = noise_item();
      item.mode = mode;
      item.address = addr;
      return item;
   endfunction

   function automatic req_type slot_item(input logic [3:0] slot, input logic [31:0] vsize,
                                         input logic [31:0] vbase, input logic [31:0] rsize,
                                         input logic [31:0] roffset);
      req_type item;
      item = noise_item();
      item.mode = MODE_WRITE;
      item.slot = slot;
      item.virtual_size = vsize;
      item.virtual_base = vbase;
      item.raw_size = rsize;
      item.raw_offset = roffset;
      return item;
   endfunction

   function automatic logic [31:0] random_word();
      case ($urandom_range(0, 4))
         0: return $urandom_range(0, 32'h4000);
         1: return $urandom & 32'hFFFF_F000;
         2: return 32'hFFFF_FFFF - $urandom_range(0, 32'h2000);
         3: return $urandom_range(32'h1000, 32'h0100_0000);
         default: return $urandom;
      endcase
   endfunction

   // aim at the edges and the inside of a loaded section
   function automatic logic [31:0] aimed_address(input mode_type mode);
      sect_type    s;
      logic [31:0] base;
      logic [31:0] span;
      s = written[$urandom_range(0, 15)];
      if (mode == MODE_V2F) begin
         base = s.virtual_base;
         span = (s.virtual_size + 32'h0000_0FFF) & 32'hFFFF_F000;
      end else begin
         base = s.raw_offset;
         span = s.raw_size;
      end
      case ($urandom_range(0, 6))
         0: return base;
         1: return base - 32'd1;
         2: return base + span - 32'd1;
         3: return base + span;
         4: return base + $urandom_range(0, 32'h3FFF);
         5: return header_now + $urandom_range(0, 2) - 32'd1;
         default: return $urandom;
      endcase
   endfunction

   task automatic send_item(input req_type item);
      while (!no_idle && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (item.mode == MODE_WRITE) begin
         written[item.slot] = {item.virtual_size, item.virtual_base,
                               item.raw_size, item.raw_offset};
      end
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [31:0] value);
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      if (idx == CSR_HEADER_SIZE) begin
         header_now = value;
      end
   endtask

   initial begin
      #(TIMEOUT_NS);
      $display("simulation failed");
      $finish;
   end

   initial begin
      logic [4:0]  phase_count [PHASES];
      logic [31:0] phase_header [PHASES];
      int          pick;
      mode_type    mode;

      foreach (written[i]) written[i] = '0;
      phase_count = '{5'd16, 5'd0, 5'd31, 5'd8, 5'd16, 5'd17, 5'd1,
                      5'($urandom_range(0, 31))};
      phase_header = '{$urandom_range(0, 32'hFFFF), 32'd0, HEADER_SIZE_RST,
                       32'hFFFF_FFFF, $urandom, 32'h0000_0800, 32'd0,
                       $urandom_range(0, 32'h3000)};

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // registers still at their reset values
      send_item(query_item(MODE_V2F, 32'h0000_0000));
      send_item(query_item(MODE_V2F, 32'h0000_0400));
      send_item(query_item(MODE_V2F, 32'h0000_0401));
      send_item(query_item(MODE_F2V, 32'h0000_0000));

      send_item(slot_item(4'd0, 32'h0000_1800, 32'h0000_2000, 32'h0000_0600, 32'h0000_0400));
      send_item(slot_item(4'd1, 32'h0000_1000, 32'h0000_2800, 32'h0000_0200, 32'h0000_0800));
      send_item(slot_item(4'd15, 32'hFFFF_F001, 32'h0001_0000, 32'h0000_0000, 32'h0000_5000));
      send_item(slot_item(4'd2, 32'h0000_2000, 32'hFFFF_F000, 32'h0000_0200, 32'hFFFF_FF00));
      send_item(slot_item(4'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
      send_item(slot_item(4'd4, 32'h0, 32'h0, 32'h0, 32'h0));

      write_csr(CSR_SECTION_COUNT, 32'd16);
      write_csr(CSR_HEADER_SIZE, HEADER_SIZE_RST);
      send_item(query_item(MODE_V2F, 32'h0000_2000));
      send_item(query_item(MODE_V2F, 32'h0000_2900));
      send_item(query_item(MODE_V2F, 32'h0000_3FFF));
      send_item(query_item(MODE_V2F, 32'h0000_4000));
      send_item(query_item(MODE_V2F, 32'h0001_0000));
      send_item(query_item(MODE_V2F, 32'hFFFF_F800));
      send_item(query_item(MODE_F2V, 32'h0000_0400));
      send_item(query_item(MODE_F2V, 32'h0000_0900));
      send_item(query_item(MODE_F2V, 32'hFFFF_FF80));
      send_item(query_item(MODE_F2V, 32'hFFFF_FFFF));
      send_item(query_item(MODE_NONE, 32'h0000_2000));

      write_csr(CSR_SECTION_COUNT, 32'hFFFF_FFFF);
      write_csr(CSR_HEADER_SIZE, 32'hFFFF_FFFF);
      send_item(query_item(MODE_V2F, 32'hFFFF_FFFF));
      send_item(query_item(MODE_F2V, 32'h0000_09FF));

      write_csr(CSR_HEADER_SIZE, 32'd0);
      write_csr(CSR_SPARE_2, $urandom);
      write_csr(CSR_SPARE_3, $urandom);
      send_item(query_item(MODE_V2F, 32'h0000_0000));
      send_item(query_item(MODE_V2F, 32'h0000_2000));

      for (int phase = 0; phase < PHASES; phase++) begin
         write_csr(CSR_SECTION_COUNT, 32'(phase_count[phase]));
         write_csr(CSR_HEADER_SIZE, phase_header[phase]);
         no_idle <= (phase == BURST_PHASE);
         if (phase == HOLD_PHASE) begin
            hold_request <= 1'b1;
         end
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (phase == PAUSE_PHASE && n == PHASE_ITEMS / 2) begin
               wait_drained();
            end
            pick = $urandom_range(0, 99);
            if (pick < 30) begin
               send_item(slot_item(4'($urandom_range(0, 15)), random_word(), random_word(),
                                   random_word(), random_word()));
            end else if (pick < 90) begin
               mode = pick[0] ? MODE_V2F : MODE_F2V;
               send_item(query_item(mode, aimed_address(mode)));
            end else begin
               send_item(noise_item());
            end
         end
      end

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (failures == 0 && outstanding == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
